// ===== src/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg: shared constants and types for the sorted table search block
// Table geometry, field widths, operation codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // fixed field widths
   localparam int ADDRESS_W   = 8;
   localparam int VALUE_W     = 32;
   localparam int POSITION_W  = 9;
   localparam int CFG_W       = 9;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } sbs_op_type;

   typedef struct packed {
      logic write_entry;   // store the incoming word in the table
      logic load_key;      // start a search: latch key, lo = 0, hi = count
      logic issue_read;    // read the table at the midpoint
      logic do_compare;    // narrow the range from the read data
      logic load_result;   // move lo and the hit flag to the output register
   } sbs_cmd_type;

   typedef struct packed {
      logic range_empty;   // lo has met hi
   } sbs_status_type;

endpackage

// ===== src/sbs_ifs.sv =====
// ----------------------------------------------------------------------------
// sbs_ifs: valid/ready channels of the sorted table search block
// Request, response and register-write channels, each with source and sink.
// ----------------------------------------------------------------------------
interface sbs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [sbs_pkg::ADDRESS_W-1:0]       address;
   logic signed [sbs_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output operation, output address, output value,
                   input ready);
   modport sink   (input valid, input operation, input address, input value,
                   output ready);
endinterface

interface sbs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sbs_pkg::POSITION_W-1:0]      position;
   logic                                found;

   modport source (output valid, output position, output found, input ready);
   modport sink   (input valid, input position, input found, output ready);
endinterface

interface sbs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sbs_pkg::CFG_W-1:0]           entries_in_use;

   modport source (output valid, output entries_in_use, input ready);
   modport sink   (input valid, input entries_in_use, output ready);
endinterface

// ===== src/sbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbs_ctrl: search sequencer
// One-hot state machine that steps the datapath through probe and compare
// cycles and owns the request ready and response valid flags.
// ----------------------------------------------------------------------------
module sbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  sbs_pkg::sbs_status_type status,
   output sbs_pkg::sbs_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_PROBE   = 3'b010,
      ST_COMPARE = 3'b100
   } sbs_state_type;

   sbs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == sbs_pkg::OP_SEARCH) begin
                  cmd.load_key = 1'b1;
                  state_in     = ST_PROBE;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.range_empty) begin
               // hold the answer until the output register is free
               if (slot_free) begin
                  cmd.load_result = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.issue_read = 1'b1;
               state_in       = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.do_compare = 1'b1;
            state_in       = ST_PROBE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/sbs_datapath.sv =====
// ----------------------------------------------------------------------------
// sbs_datapath: table memory and halving-search registers
// Holds the table, the entries_in_use register, the lo/hi bounds, the key
// and the output register, and acts on commands from the sequencer.
// ----------------------------------------------------------------------------
module sbs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [sbs_pkg::CFG_W-1:0]           csr_data,
   input  logic [sbs_pkg::ADDRESS_W-1:0]       req_address,
   input  logic signed [sbs_pkg::VALUE_W-1:0]  req_value,
   input  sbs_pkg::sbs_cmd_type                cmd,
   output sbs_pkg::sbs_status_type             status,
   output logic [sbs_pkg::POSITION_W-1:0]      rsp_position,
   output logic                                rsp_found
);

   logic signed [sbs_pkg::VALUE_W-1:0]  table_mem [sbs_pkg::TABLE_DEPTH];

   logic [sbs_pkg::CFG_W-1:0]           count_ff;
   logic [sbs_pkg::COUNT_W-1:0]         lo_ff, lo_in;
   logic [sbs_pkg::COUNT_W-1:0]         hi_ff, hi_in;
   logic [sbs_pkg::COUNT_W-1:0]         mid;
   logic [sbs_pkg::COUNT_W-1:0]         search_count;
   logic signed [sbs_pkg::VALUE_W-1:0]  key_ff;
   logic signed [sbs_pkg::VALUE_W-1:0]  rd_data_ff;
   logic                                hit_ff, hit_in;
   logic [sbs_pkg::POSITION_W-1:0]      position_ff;
   logic                                found_ff;
   logic                                write_en;

   // saturate the register to the table depth
   assign search_count = (32'(count_ff) > sbs_pkg::TABLE_DEPTH)
                       ? sbs_pkg::COUNT_W'(sbs_pkg::TABLE_DEPTH)
                       : sbs_pkg::COUNT_W'(count_ff);

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign write_en = cmd.write_entry && (32'(req_address) < sbs_pkg::TABLE_DEPTH);

   assign status.range_empty = (lo_ff >= hi_ff);
   assign rsp_position       = position_ff;
   assign rsp_found          = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sbs_pkg::CFG_RESET;
      end else if (csr_write) begin
         count_ff <= csr_data;
      end
   end

   // table store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         table_mem[sbs_pkg::IDX_W'(req_address)] <= req_value;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= table_mem[mid[sbs_pkg::IDX_W-1:0]];
      end
   end

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      hit_in = hit_ff;
      if (cmd.load_key) begin
         lo_in  = '0;
         hi_in  = search_count;
         hit_in = 1'b0;
      end else if (cmd.do_compare) begin
         if (rd_data_ff < key_ff) begin
            lo_in = mid + sbs_pkg::COUNT_W'(1);
         end else begin
            // hi always ends at the reported position, so track equality here
            hi_in  = mid;
            hit_in = (rd_data_ff == key_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff  <= '0;
         hi_ff  <= '0;
         hit_ff <= 1'b0;
      end else begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_value;
      end
      if (cmd.load_result) begin
         position_ff <= sbs_pkg::POSITION_W'(lo_ff);
         found_ff    <= hit_ff;
      end
   end

endmodule

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search: lower-bound search over a sorted signed table
// Write words fill the table; search words return the lowest position whose
// entry is not less than the key, and whether that entry equals the key.
// ----------------------------------------------------------------------------
// Sequencing: a write word is stored on acceptance and gives no response. A
//   search word runs S halving steps (at most 9 for a 256-entry table), then
//   loads its result into the output register once that is free, raising response valid.
// Throughput: one word at a time; each halving step is a registered table
//   read followed by a compare. A new word is taken the cycle after a search
//   ends, even while its response waits.
// Reset: clears the sequencer and sets entries_in_use to 256; table contents
//   stay undefined until written.
module sorted_table_binary_search (
   input  logic       clock,
   input  logic       reset,
   sbs_req_if.sink    req_bus,
   sbs_rsp_if.source  rsp_bus,
   sbs_csr_if.sink    csr_bus
);

   sbs_pkg::sbs_cmd_type    cmd;
   sbs_pkg::sbs_status_type status;

   // the register write is a plain register load, so never stall it
   assign csr_bus.ready = 1'b1;

   // sequencer: accepts words, steps the search, drives response valid
   sbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: table memory, bounds, key and the output register
   sbs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_bus.valid),
      .csr_data     (csr_bus.entries_in_use),
      .req_address  (req_bus.address),
      .req_value    (req_bus.value),
      .cmd          (cmd),
      .status       (status),
      .rsp_position (rsp_bus.position),
      .rsp_found    (rsp_bus.found)
   );

endmodule

// ===== src/sbs_checker.sv =====
// ----------------------------------------------------------------------------
// sbs_checker: port-level checks for the sorted table search block
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module sbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sbs_pkg::POSITION_W-1:0]   rsp_position,
   input logic                             rsp_found
);

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_position) && $stable(rsp_found))
      else $error("response payload changed while stalled");

   // a hit always points inside the table
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> 32'(rsp_position) < sbs_pkg::TABLE_DEPTH)
      else $error("hit reported at a position past the table");

   // with no response pending, no word gives a response in the cycle right after it is accepted
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after acceptance");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_position (rsp_bus.position),
   .rsp_found    (rsp_bus.found)
);
